>>> rtl/mic_pkg.sv
// Shared types and constants of the multithread instruction cache.
`default_nettype none
package mic_pkg;

   localparam int LINE_BYTES = 64;
   localparam int OFF_W      = 6;
   localparam int WAYS       = 4;
   localparam int WAY_W      = 2;
   localparam int SETS       = 4;
   localparam int SET_W      = 2;
   localparam int ADDR_W     = 48;
   localparam int TAG_W      = ADDR_W - OFF_W - SET_W;
   localparam int NLINES     = SETS * WAYS;
   localparam int LINE_W     = SET_W + WAY_W;
   localparam int WORD_W     = OFF_W - 3;
   localparam int TID_W      = 8;
   localparam int REQ_W      = 136;
   localparam int RSP_W      = 152;
   localparam logic [8:0]  REF_MAX     = 9'd511;
   localparam logic [7:0]  LINE_LIMIT  = 8'(LINE_BYTES);

   localparam logic [2:0] OP_FETCH_THREAD = 3'd0;
   localparam logic [2:0] OP_FETCH_CREATE = 3'd1;
   localparam logic [2:0] OP_RELEASE      = 3'd2;
   localparam logic [2:0] OP_FILL_WORD    = 3'd3;
   localparam logic [2:0] OP_INVALIDATE   = 3'd4;
   localparam logic [2:0] OP_READ         = 3'd5;

   localparam logic [2:0] ST_HIT      = 3'd0;
   localparam logic [2:0] ST_DELAYED  = 3'd1;
   localparam logic [2:0] ST_NO_LINE  = 3'd2;
   localparam logic [2:0] ST_CROSSES  = 3'd3;
   localparam logic [2:0] ST_NOT_EXEC = 3'd4;
   localparam logic [2:0] ST_BAD_LINE = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   typedef enum logic [1:0] {
      LS_EMPTY   = 2'd0,
      LS_LOADING = 2'd1,
      LS_FULL    = 2'd2,
      LS_INVALID = 2'd3
   } line_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_EXEC,
      BK_READ
   } back_state_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      line_state_type   state;
      logic [8:0]       refs;
      logic [31:0]      stamp;
      logic [TID_W-1:0] head;
      logic [TID_W-1:0] tail;
      logic             wvalid;
      logic             create;
   } line_type;

   typedef struct packed {
      logic [2:0]        op;
      logic [OFF_W-1:0]  off;
      logic [SET_W-1:0]  set;
      logic [TAG_W-1:0]  tag;
      logic [ADDR_W-1:0] line_addr;
      logic [3:0]        rcnt;
      logic [TID_W-1:0]  tid;
      logic [3:0]        li;
      logic [63:0]       dw;
      logic              early;
      logic [2:0]        early_status;
   } item_type;

   typedef struct packed {
      logic [7:0]        wake_tail;
      logic [7:0]        wake_head;
      logic              wake_valid;
      logic              resume_creation;
      logic [63:0]       read_data;
      logic [ADDR_W-1:0] request_address;
      logic              request_valid;
      logic              previous_head_valid;
      logic [7:0]        previous_head;
      logic [3:0]        line_index_out;
      logic [2:0]        status;
   } result_type;

endpackage
`default_nettype wire

>>> rtl/multithread_instruction_cache.sv
// Top level of the multithread instruction cache.
//
//   channel | direction | beat contents
//   req_    | in        | operation, address, byte_count, thread_id, line_index,
//           |           | data_word, executable
//   rsp_    | out       | status, line index, waiting list, memory request,
//           |           | read data, wake list
//
// Back end: BK_EXEC does lookup and line update; a read then passes BK_READ, as
// its data memory output is registered. Items pass one at a time.
// Reset clears every line record to empty and the stamp counter to zero.
// A two-entry queue lets requests be taken while a result waits on rsp_tready.
`default_nettype none
module multithread_instruction_cache
   import mic_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   // [2:0] operation, [50:3] address, [57:51] byte_count, [65:58] thread_id,
   // [69:66] line_index, [133:70] data_word, [134] executable, [135] zero
   input  wire logic [REQ_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   // [2:0] status, [6:3] line_index_out, [14:7] previous_head,
   // [15] previous_head_valid, [16] request_valid, [64:17] request_address,
   // [128:65] read_data, [129] resume_creation, [130] wake_valid,
   // [138:131] wake_head, [146:139] wake_tail, [151:147] zero
   output logic [RSP_W-1:0]      rsp_tdata
);

   item_type   f_item, q_head;
   logic       q_full, q_empty, q_pop;
   result_type res;

   mic_front u_front (
      .op         (req_tdata[2:0]),
      .address    (req_tdata[50:3]),
      .byte_count (req_tdata[57:51]),
      .thread_id  (req_tdata[65:58]),
      .line_index (req_tdata[69:66]),
      .data_word  (req_tdata[133:70]),
      .executable (req_tdata[134]),
      .item       (f_item)
   );

   assign req_tready = !q_full;

   mic_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid && !q_full),
      .push_item (f_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head_item (q_head)
   );

   mic_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_item    (q_head),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (res)
   );

   // Pack result beat
   assign rsp_tdata = {5'd0, res};

endmodule
`default_nettype wire

>>> rtl/mic_front.sv
// Front end: takes request beats, splits the address and screens fetches and reads.
`default_nettype none
module mic_front
   import mic_pkg::*;
(
   input  wire logic [2:0]        op,
   input  wire logic [ADDR_W-1:0] address,
   input  wire logic [6:0]        byte_count,
   input  wire logic [7:0]        thread_id,
   input  wire logic [3:0]        line_index,
   input  wire logic [63:0]       data_word,
   input  wire logic              executable,
   output item_type               item
);

   logic [OFF_W-1:0] off;
   logic [3:0]       rcnt;
   logic [7:0]       fend;
   logic [7:0]       rend;

   assign off  = address[OFF_W-1:0];
   assign rcnt = (byte_count > 7'd8) ? 4'd8 : byte_count[3:0];
   assign fend = 8'(off) + 8'(byte_count);
   assign rend = 8'(off) + 8'(rcnt);

   // Split address and flag early exits
   always_comb begin
      item.op        = op;
      item.off       = off;
      item.set       = address[OFF_W +: SET_W];
      item.tag       = address[ADDR_W-1 -: TAG_W];
      item.line_addr = {address[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
      item.rcnt      = rcnt;
      item.tid       = thread_id;
      item.li        = line_index;
      item.dw        = data_word;
      item.early        = 1'b0;
      item.early_status = ST_DONE;
      if (op == OP_FETCH_THREAD || op == OP_FETCH_CREATE) begin
         if (!executable) begin
            item.early = 1'b1;
            item.early_status = ST_NOT_EXEC;
         end else if (fend > LINE_LIMIT) begin
            item.early = 1'b1;
            item.early_status = ST_CROSSES;
         end
      end else if (op == OP_READ && rend > LINE_LIMIT) begin
         item.early = 1'b1;
         item.early_status = ST_CROSSES;
      end
   end

endmodule
`default_nettype wire

>>> rtl/mic_queue.sv
// Two-entry queue of classified items between front and back end.
`default_nettype none
module mic_queue
   import mic_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire item_type push_item,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output item_type      head_item
);

   item_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign head_item = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule
`default_nettype wire

>>> rtl/mic_back.sv
// Back end: line lookup, line record update, data memory and result register.
`default_nettype none
module mic_back
   import mic_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     q_empty,
   input  wire item_type q_item,
   output logic          q_pop,
   output logic          out_valid,
   input  wire logic     out_ready,
   output result_type    out_data
);

   back_state_type state_ff, state_in;
   item_type       work_ff;
   line_type       lines_ff [NLINES];
   logic [31:0]    stamp_ff;
   logic [63:0]    mem [NLINES * (LINE_BYTES / 8)];
   logic [63:0]    rd_lo_ff, rd_hi_ff;
   logic           out_valid_ff;
   result_type     out_ff;

   logic           out_free;
   logic           exec_fire, read_fire, load_work;
   logic           hit, empty_found, repl_found;
   logic [LINE_W-1:0] hit_idx, empty_idx, repl_idx, sel_idx;
   logic [31:0]    repl_stamp;
   line_type       cur, line_in;
   logic           line_we, mem_we, stamp_inc;
   result_type     res, rd_res;
   logic [WORD_W-1:0] word;
   logic [LINE_W-1:0] rline;
   logic [127:0]   pair;
   logic [63:0]    shifted, rdata;

   assign out_free  = !out_valid_ff || out_ready;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign word      = work_ff.off[OFF_W-1:3];
   assign rline     = work_ff.li[LINE_W-1:0];

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!q_empty) state_in = BK_EXEC;
         BK_EXEC: begin
            if (work_ff.op == OP_READ && res.status == ST_DONE && !work_ff.early)
               state_in = BK_READ;
            else if (out_free)
               state_in = BK_IDLE;
         end
         BK_READ: if (out_free) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      load_work = 1'b0;
      exec_fire = 1'b0;
      read_fire = 1'b0;
      unique case (state_ff)
         BK_IDLE: load_work = !q_empty;
         BK_EXEC: exec_fire = (state_in == BK_READ) || out_free;
         BK_READ: read_fire = out_free;
         default: ;
      endcase
   end
   assign q_pop = load_work;

   // Search the set: first tag hit, last empty way, oldest unreferenced way
   always_comb begin
      hit = 1'b0; empty_found = 1'b0; repl_found = 1'b0;
      hit_idx = '0; empty_idx = '0; repl_idx = '0; repl_stamp = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (lines_ff[{work_ff.set, WAY_W'(w)}].state == LS_EMPTY) begin
            empty_found = 1'b1;
            empty_idx = {work_ff.set, WAY_W'(w)};
         end else if (lines_ff[{work_ff.set, WAY_W'(w)}].tag == work_ff.tag) begin
            if (!hit) begin
               hit = 1'b1;
               hit_idx = {work_ff.set, WAY_W'(w)};
            end
         end else if (lines_ff[{work_ff.set, WAY_W'(w)}].state != LS_INVALID &&
                      lines_ff[{work_ff.set, WAY_W'(w)}].refs == 9'd0 &&
                      (!repl_found ||
                       lines_ff[{work_ff.set, WAY_W'(w)}].stamp < repl_stamp)) begin
            repl_found = 1'b1;
            repl_idx = {work_ff.set, WAY_W'(w)};
            repl_stamp = lines_ff[{work_ff.set, WAY_W'(w)}].stamp;
         end
      end
   end

   // Carry out the operation on one line record
   always_comb begin
      res = '0;
      res.status = ST_DONE;
      line_we = 1'b0; mem_we = 1'b0; stamp_inc = 1'b0;
      sel_idx = hit ? hit_idx : (empty_found ? empty_idx : repl_idx);
      if (work_ff.op == OP_RELEASE || work_ff.op == OP_READ) sel_idx = rline;
      cur = lines_ff[sel_idx];
      line_in = cur;
      if (work_ff.early) begin
         res.status = work_ff.early_status;
         if (work_ff.op == OP_READ) res.line_index_out = work_ff.li;
      end else begin
         unique case (work_ff.op)
            OP_FETCH_THREAD, OP_FETCH_CREATE: begin
               if (!hit && !empty_found && !repl_found) begin
                  res.status = ST_NO_LINE;
               end else begin
                  line_we = 1'b1;
                  stamp_inc = 1'b1;
                  line_in.stamp = stamp_ff;
                  res.line_index_out = 4'(sel_idx);
                  res.status = ST_DELAYED;
                  if (hit) begin
                     if (cur.refs < REF_MAX) line_in.refs = cur.refs + 9'd1;
                     if (cur.state == LS_FULL) begin
                        res.status = ST_HIT;
                     end else if (work_ff.op == OP_FETCH_THREAD) begin
                        res.previous_head = cur.head;
                        res.previous_head_valid = cur.wvalid;
                        if (!cur.wvalid) line_in.tail = work_ff.tid;
                        line_in.head = work_ff.tid;
                        line_in.wvalid = 1'b1;
                     end else begin
                        line_in.create = 1'b1;
                     end
                  end else begin
                     line_in.tag = work_ff.tag;
                     line_in.refs = 9'd1;
                     line_in.state = LS_LOADING;
                     line_in.create = (work_ff.op == OP_FETCH_CREATE);
                     line_in.wvalid = (work_ff.op == OP_FETCH_THREAD);
                     line_in.head = (work_ff.op == OP_FETCH_THREAD) ? work_ff.tid : '0;
                     line_in.tail = (work_ff.op == OP_FETCH_THREAD) ? work_ff.tid : '0;
                     res.request_valid = 1'b1;
                     res.request_address = work_ff.line_addr;
                  end
               end
            end
            OP_RELEASE: begin
               res.line_index_out = work_ff.li;
               if (cur.refs != 9'd0) begin
                  line_we = 1'b1;
                  line_in.refs = cur.refs - 9'd1;
                  if (cur.refs == 9'd1 && cur.state == LS_INVALID)
                     line_in.state = LS_EMPTY;
               end
            end
            OP_FILL_WORD: begin
               if (hit && cur.state != LS_FULL) begin
                  mem_we = 1'b1;
                  res.line_index_out = 4'(sel_idx);
                  if (word == {WORD_W{1'b1}}) begin
                     line_we = 1'b1;
                     if (cur.state == LS_LOADING) line_in.state = LS_FULL;
                     res.resume_creation = cur.create;
                     line_in.create = 1'b0;
                     if (cur.wvalid) begin
                        res.wake_valid = 1'b1;
                        res.wake_head = cur.head;
                        res.wake_tail = cur.tail;
                     end
                     line_in.wvalid = 1'b0;
                     line_in.head = '0;
                     line_in.tail = '0;
                  end
               end
            end
            OP_INVALIDATE: begin
               if (hit) begin
                  line_we = 1'b1;
                  if (cur.state == LS_FULL)
                     line_in.state = (cur.refs == 9'd0) ? LS_EMPTY : LS_INVALID;
                  else if (cur.state == LS_LOADING)
                     line_in.state = LS_INVALID;
               end
            end
            OP_READ: begin
               res.line_index_out = work_ff.li;
               if (cur.state == LS_EMPTY || cur.state == LS_LOADING ||
                   cur.tag != work_ff.tag)
                  res.status = ST_BAD_LINE;
            end
            default: ;
         endcase
      end
   end

   // Pick the read bytes out of the two neighbouring words
   always_comb begin
      pair = {rd_hi_ff, rd_lo_ff};
      shifted = 64'(pair >> {work_ff.off[2:0], 3'b000});
      for (int k = 0; k < 8; k++)
         rdata[k*8 +: 8] = (4'(k) < work_ff.rcnt) ? shifted[k*8 +: 8] : 8'd0;
      rd_res = res;
      rd_res.read_data = rdata;
   end

   // Control registers and line records
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
         stamp_ff     <= '0;
         for (int i = 0; i < NLINES; i++) begin
            lines_ff[i] <= '{tag: '0, state: LS_EMPTY, refs: '0, stamp: '0,
                             head: '0, tail: '0, wvalid: 1'b0, create: 1'b0};
         end
      end else begin
         state_ff <= state_in;
         if (exec_fire && line_we) lines_ff[sel_idx] <= line_in;
         if (exec_fire && stamp_inc) stamp_ff <= stamp_ff + 32'd1;
         if ((exec_fire && state_in != BK_READ) || read_fire)
            out_valid_ff <= 1'b1;
         else if (out_ready)
            out_valid_ff <= 1'b0;
      end
   end

   // Work register and result payload
   always_ff @(posedge clock) begin
      if (load_work) work_ff <= q_item;
      if (exec_fire && state_in != BK_READ) out_ff <= res;
      if (read_fire) out_ff <= rd_res;
   end

   // Line data memory: one write, two registered reads
   always_ff @(posedge clock) begin
      if (exec_fire && mem_we) mem[{sel_idx, word}] <= work_ff.dw;
      if (exec_fire) begin
         rd_lo_ff <= mem[{rline, word}];
         rd_hi_ff <= mem[{rline, word + WORD_W'(word != {WORD_W{1'b1}})}];
      end
   end

endmodule
`default_nettype wire
